// ===== rtl/iirdf2_pkg.sv =====
// Shared types, constants and the microcode ROM for the direct form II IIR filter.
// No dependencies; every other file in rtl/ uses this package by scoped names.
package iirdf2_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int STATE_W   = 24;
    localparam int FRAC_W    = 14;
    localparam int PROD_W    = COEF_W + STATE_W;
    // three feedback/feedforward products plus the sample term, with headroom
    localparam int ACC_W     = PROD_W + 3;
    localparam int Q_W       = ACC_W - FRAC_W;
    localparam int MAX_ORDER = 3;
    localparam int ORDER_DEF = 3;
    localparam int PC_W      = 4;
    localparam int TAP_W     = 2;
    localparam int REG_IDX_W = 3;

    localparam logic signed [ACC_W-1:0] HALF_Q    = ACC_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [Q_W-1:0]   STATE_MAX = Q_W'((1 << (STATE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0]   STATE_MIN = -Q_W'(1 << (STATE_W - 1));
    localparam logic signed [Q_W-1:0]   OUT_MAX   = Q_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0]   OUT_MIN   = -Q_W'(1 << (SAMPLE_W - 1));

    // coefficient register indexes
    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_B3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_A3 = 3'd6;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t b3;
        coef_t a1;
        coef_t a2;
        coef_t a3;
    } coef_bank_t;

    typedef enum logic [2:0] {
        CS_B0 = 3'd0,
        CS_B1 = 3'd1,
        CS_B2 = 3'd2,
        CS_B3 = 3'd3,
        CS_A1 = 3'd4,
        CS_A2 = 3'd5,
        CS_A3 = 3'd6
    } coef_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD   = 3'd0,
        ACC_LOAD_X = 3'd1,
        ACC_SUB    = 3'd2,
        ACC_ADD    = 3'd3,
        ACC_LOAD_P = 3'd4
    } acc_op_t;

    typedef enum logic [1:0] {
        COND_NONE = 2'd0,
        COND_IN   = 2'd1,
        COND_OUT  = 2'd2
    } cond_t;

    typedef struct packed {
        coef_sel_t        coef_sel;
        logic [TAP_W-1:0] tap;       // 0 selects the new state w
        acc_op_t          acc_op;
        logic             latch_w;
        logic             emit;
        cond_t            cond;      // hold the step until this is true
        logic             jump;
        logic [PC_W-1:0]  target;
    } ctrl_word_t;

    typedef struct packed {
        ctrl_word_t cw;
        logic       advance;
        logic       in_ready;
    } seq_ctrl_t;

    localparam ctrl_word_t CW_NOP = '{
        coef_sel: CS_B0, tap: '0, acc_op: ACC_HOLD, latch_w: 1'b0, emit: 1'b0,
        cond: COND_NONE, jump: 1'b0, target: '0
    };

    // One control word per step. The multiplier issued in step k is
    // accumulated in step k+1.
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] addr);
        ctrl_word_t w;
        w = CW_NOP;
        case (addr)
            4'd0: begin
                w.coef_sel = CS_A1; w.tap = 2'd1; w.acc_op = ACC_LOAD_X;
                w.cond = COND_IN;
            end
            4'd1: begin
                w.coef_sel = CS_A2; w.tap = 2'd2; w.acc_op = ACC_SUB;
            end
            4'd2: begin
                w.coef_sel = CS_A3; w.tap = 2'd3; w.acc_op = ACC_SUB;
            end
            4'd3: begin
                w.coef_sel = CS_B1; w.tap = 2'd1; w.acc_op = ACC_SUB;
            end
            4'd4: begin
                w.coef_sel = CS_B2; w.tap = 2'd2; w.acc_op = ACC_LOAD_P;
                w.latch_w = 1'b1;
            end
            4'd5: begin
                w.coef_sel = CS_B3; w.tap = 2'd3; w.acc_op = ACC_ADD;
            end
            4'd6: begin
                w.coef_sel = CS_B0; w.tap = 2'd0; w.acc_op = ACC_ADD;
            end
            4'd7: begin
                w.acc_op = ACC_ADD;
            end
            4'd8: begin
                w.emit = 1'b1; w.cond = COND_OUT; w.jump = 1'b1; w.target = '0;
            end
            default: begin
                w.jump = 1'b1; w.target = '0;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/iirdf2_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional branching.
// Depends on iirdf2_pkg.
module iirdf2_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic                  out_free,
    output iirdf2_pkg::seq_ctrl_t ctrl
);

    logic [iirdf2_pkg::PC_W-1:0] pc_reg;
    logic [iirdf2_pkg::PC_W-1:0] pc_next;
    iirdf2_pkg::ctrl_word_t      cw;
    logic                        cond_ok;

    assign cw = iirdf2_pkg::ucode_rom(pc_reg);

    always_comb begin
        case (cw.cond)
            iirdf2_pkg::COND_NONE: cond_ok = 1'b1;
            iirdf2_pkg::COND_IN:   cond_ok = in_valid;
            iirdf2_pkg::COND_OUT:  cond_ok = out_free;
            default:               cond_ok = 1'b1;
        endcase
    end

    always_comb begin
        if (!cond_ok) begin
            pc_next = pc_reg;
        end else if (cw.jump) begin
            pc_next = cw.target;
        end else begin
            pc_next = pc_reg + iirdf2_pkg::PC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.cw       = cw;
    assign ctrl.advance  = cond_ok;
    assign ctrl.in_ready = (cw.cond == iirdf2_pkg::COND_IN);

endmodule

// ===== rtl/iirdf2_dp.sv =====
// Datapath: delay line, shared multiplier, accumulator, rounding and saturation.
// Depends on iirdf2_pkg; driven by control words from iirdf2_seq.
module iirdf2_dp #(
    parameter int ORDER = iirdf2_pkg::ORDER_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  iirdf2_pkg::seq_ctrl_t                ctrl,
    input  iirdf2_pkg::coef_bank_t               coefs,
    input  logic signed [iirdf2_pkg::SAMPLE_W-1:0] sample_in,
    output logic signed [iirdf2_pkg::SAMPLE_W-1:0] y_out,
    output logic                                 clip_out
);

    localparam int ACC_W = iirdf2_pkg::ACC_W;

    logic signed [iirdf2_pkg::STATE_W-1:0] delay_reg [ORDER];
    logic signed [iirdf2_pkg::STATE_W-1:0] w_reg;
    logic                                  w_hit_reg;
    logic signed [iirdf2_pkg::PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]               acc_reg;
    logic signed [ACC_W-1:0]               acc_next;

    iirdf2_pkg::coef_t                     mul_coef;
    logic signed [iirdf2_pkg::STATE_W-1:0] mul_state;
    logic signed [iirdf2_pkg::PROD_W-1:0]  prod_next;

    logic signed [ACC_W-1:0]               rnd_sum;
    logic signed [iirdf2_pkg::Q_W-1:0]     q;
    logic signed [iirdf2_pkg::STATE_W-1:0] w_sat;
    logic                                  w_hit;
    logic                                  y_hit;
    logic signed [ACC_W-1:0]               x_scaled;

    always_comb begin
        case (ctrl.cw.coef_sel)
            iirdf2_pkg::CS_B0: mul_coef = coefs.b0;
            iirdf2_pkg::CS_B1: mul_coef = coefs.b1;
            iirdf2_pkg::CS_B2: mul_coef = coefs.b2;
            iirdf2_pkg::CS_B3: mul_coef = coefs.b3;
            iirdf2_pkg::CS_A1: mul_coef = coefs.a1;
            iirdf2_pkg::CS_A2: mul_coef = coefs.a2;
            iirdf2_pkg::CS_A3: mul_coef = coefs.a3;
            default:           mul_coef = '0;
        endcase
    end

    // taps beyond ORDER read as zero, which drops their products
    always_comb begin
        mul_state = '0;
        if (ctrl.cw.tap == '0) begin
            mul_state = w_reg;
        end
        for (int i = 0; i < ORDER; i++) begin
            if (ctrl.cw.tap == iirdf2_pkg::TAP_W'(i + 1)) begin
                mul_state = delay_reg[i];
            end
        end
    end

    assign prod_next = mul_coef * mul_state;

    assign x_scaled = {{(ACC_W - iirdf2_pkg::SAMPLE_W - iirdf2_pkg::FRAC_W){sample_in[
                          iirdf2_pkg::SAMPLE_W-1]}}, sample_in, {iirdf2_pkg::FRAC_W{1'b0}}};

    // round half up: add half an LSB, then floor
    assign rnd_sum = acc_reg + iirdf2_pkg::HALF_Q;
    assign q       = rnd_sum[ACC_W-1:iirdf2_pkg::FRAC_W];

    always_comb begin
        w_hit = 1'b0;
        w_sat = q[iirdf2_pkg::STATE_W-1:0];
        if (q > iirdf2_pkg::STATE_MAX) begin
            w_hit = 1'b1;
            w_sat = iirdf2_pkg::STATE_MAX[iirdf2_pkg::STATE_W-1:0];
        end else if (q < iirdf2_pkg::STATE_MIN) begin
            w_hit = 1'b1;
            w_sat = iirdf2_pkg::STATE_MIN[iirdf2_pkg::STATE_W-1:0];
        end
    end

    always_comb begin
        y_hit = 1'b0;
        y_out = q[iirdf2_pkg::SAMPLE_W-1:0];
        if (q > iirdf2_pkg::OUT_MAX) begin
            y_hit = 1'b1;
            y_out = iirdf2_pkg::OUT_MAX[iirdf2_pkg::SAMPLE_W-1:0];
        end else if (q < iirdf2_pkg::OUT_MIN) begin
            y_hit = 1'b1;
            y_out = iirdf2_pkg::OUT_MIN[iirdf2_pkg::SAMPLE_W-1:0];
        end
    end

    assign clip_out = w_hit_reg | y_hit;

    always_comb begin
        case (ctrl.cw.acc_op)
            iirdf2_pkg::ACC_HOLD:   acc_next = acc_reg;
            iirdf2_pkg::ACC_LOAD_X: acc_next = x_scaled;
            iirdf2_pkg::ACC_SUB:    acc_next = acc_reg - ACC_W'(prod_reg);
            iirdf2_pkg::ACC_ADD:    acc_next = acc_reg + ACC_W'(prod_reg);
            iirdf2_pkg::ACC_LOAD_P: acc_next = ACC_W'(prod_reg);
            default:                acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (ctrl.advance) begin
            acc_reg <= acc_next;
        end
        if (ctrl.advance && ctrl.cw.latch_w) begin
            w_reg     <= w_sat;
            w_hit_reg <= w_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ORDER; i++) begin
                delay_reg[i] <= '0;
            end
        end else if (ctrl.advance && ctrl.cw.emit) begin
            delay_reg[0] <= w_reg;
            for (int i = 1; i < ORDER; i++) begin
                delay_reg[i] <= delay_reg[i-1];
            end
        end
    end

endmodule

// ===== rtl/iir_direct_form_two_filter.sv =====
// Top level of the direct form II IIR filter: coefficient registers, output register.
// Depends on iirdf2_pkg, iirdf2_seq and iirdf2_dp.
//
//  channel   ports                              direction  width
//  -------   --------------------------------   ---------  -----------------
//  input     s_valid s_ready s_sample_in        in         16 signed
//  result    m_valid m_ready m_sample_out       out        16 signed, 1 flag
//            m_clipped
//  config    cfg_wr_en cfg_index cfg_data       in         3 index, 18 data
//
//  A sample is accepted in step 0 and its result reaches the result register
//  in the last step; no new sample is taken until the sequencer is back in
//  step 0. One shared 18x24 multiplier does all 2*3+1 products, one issued
//  per microcode step; one more step adds the last product and one rounds
//  and registers the output.
//  Reset (synchronous, active low) clears the step counter, the delay line and
//  the output valid; coefficients return to b0 = 1.0, all others zero.
//  The next sample is accepted while a result waits; the sequencer holds in
//  step 0 until a sample arrives and in its last step while the output
//  register is still occupied.
module iir_direct_form_two_filter #(
    parameter int ORDER = iirdf2_pkg::ORDER_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input sample transaction
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [iirdf2_pkg::SAMPLE_W-1:0] s_sample_in,
    // result transaction
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [iirdf2_pkg::SAMPLE_W-1:0] m_sample_out,
    output logic                                   m_clipped,
    // coefficient writes
    input  logic                                   cfg_wr_en,
    input  logic [iirdf2_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [iirdf2_pkg::COEF_W-1:0]          cfg_data
);

    iirdf2_pkg::coef_bank_t                coef_reg;
    iirdf2_pkg::seq_ctrl_t                 ctrl;
    logic signed [iirdf2_pkg::SAMPLE_W-1:0] y_out;
    logic                                  clip_out;
    logic                                  out_free;
    logic                                  emit_go;

    logic                                  m_valid_reg;
    logic signed [iirdf2_pkg::SAMPLE_W-1:0] m_sample_out_reg;
    logic                                  m_clipped_reg;

    // output register may be refilled in the cycle it is drained
    assign out_free = !m_valid_reg || m_ready;
    assign emit_go  = ctrl.advance && ctrl.cw.emit;

    iirdf2_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    iirdf2_dp #(
        .ORDER (ORDER)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .coefs     (coef_reg),
        .sample_in (s_sample_in),
        .y_out     (y_out),
        .clip_out  (clip_out)
    );

    // coefficient bank; writes to unused indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.b0 <= iirdf2_pkg::COEF_ONE;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.b3 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
            coef_reg.a3 <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                iirdf2_pkg::REG_B0: coef_reg.b0 <= cfg_data;
                iirdf2_pkg::REG_B1: coef_reg.b1 <= cfg_data;
                iirdf2_pkg::REG_B2: coef_reg.b2 <= cfg_data;
                iirdf2_pkg::REG_B3: coef_reg.b3 <= cfg_data;
                iirdf2_pkg::REG_A1: coef_reg.a1 <= cfg_data;
                iirdf2_pkg::REG_A2: coef_reg.a2 <= cfg_data;
                iirdf2_pkg::REG_A3: coef_reg.a3 <= cfg_data;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_go) begin
            m_sample_out_reg <= y_out;
            m_clipped_reg    <= clip_out;
        end
    end

    assign s_ready      = ctrl.in_ready;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;
    assign m_clipped    = m_clipped_reg;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for iir_direct_form_two_filter (direct form II IIR, order 3).
// Depends on iirdf2_pkg and the filter RTL; predicts each output sample from Q4.14
// coefficients and checks it against the result channel.
module testbench;

    localparam int FILTER_ORDER = iirdf2_pkg::ORDER_DEF;
    // Settling wait in drain_filter after the last expected result.
    localparam int DRAIN_CYCLES = 12;

    // Index 7 has no register behind it; writes there must be dropped.
    localparam logic [iirdf2_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam iirdf2_pkg::coef_t COEF_MAX  = iirdf2_pkg::coef_t'(18'h1FFFF);
    localparam iirdf2_pkg::coef_t COEF_MIN  = iirdf2_pkg::coef_t'(18'h20000);
    localparam iirdf2_pkg::coef_t COEF_HALF = iirdf2_pkg::coef_t'(18'h02000);

    localparam logic signed [iirdf2_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [iirdf2_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    localparam logic [iirdf2_pkg::REG_IDX_W-1:0] COEF_REGS [7] = '{
        iirdf2_pkg::REG_B0, iirdf2_pkg::REG_B1, iirdf2_pkg::REG_B2, iirdf2_pkg::REG_B3,
        iirdf2_pkg::REG_A1, iirdf2_pkg::REG_A2, iirdf2_pkg::REG_A3
    };

    typedef struct {
        logic signed [iirdf2_pkg::SAMPLE_W-1:0] sample_out;
        logic                                   clipped;
    } filter_result_t;

    logic                                   aclk;
    logic                                   aresetn;
    logic                                   s_valid;
    logic                                   s_ready;
    logic signed [iirdf2_pkg::SAMPLE_W-1:0] s_sample_in;
    logic                                   m_valid;
    logic                                   m_ready;
    logic signed [iirdf2_pkg::SAMPLE_W-1:0] m_sample_out;
    logic                                   m_clipped;
    logic                                   cfg_wr_en;
    logic [iirdf2_pkg::REG_IDX_W-1:0]       cfg_index;
    logic [iirdf2_pkg::COEF_W-1:0]          cfg_data;

    // Predictor copy of the coefficient bank and the delay line.
    iirdf2_pkg::coef_t                     feedforward [0:iirdf2_pkg::MAX_ORDER];
    iirdf2_pkg::coef_t                     feedback    [1:iirdf2_pkg::MAX_ORDER];
    logic signed [iirdf2_pkg::STATE_W-1:0] delay_line  [1:iirdf2_pkg::MAX_ORDER];

    filter_result_t expected_outputs [$];
    int             error_count;

    // Idle controls, shared between the sequence and the result channel process.
    bit sender_gaps;
    bit receiver_stalls;
    int long_hold_cycles;

    iir_direct_form_two_filter #(
        .ORDER(FILTER_ORDER)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_in (s_sample_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample_out(m_sample_out),
        .m_clipped   (m_clipped),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor: one filter step in exact 64-bit arithmetic.
    //   w = round(x*2^14 - sum a_k*d_k), saturated to 24 bits
    //   y = round(b0*w + sum b_k*d_k),   saturated to 16 bits
    // round = add half an LSB, then floor (arithmetic shift).
    // ------------------------------------------------------------------
    function automatic filter_result_t predict_filter_output(
        input logic signed [iirdf2_pkg::SAMPLE_W-1:0] x
    );
        longint         acc;
        longint         w_new;
        longint         y;
        filter_result_t r;
        r.clipped = 1'b0;
        acc = longint'(x) * (longint'(1) << iirdf2_pkg::FRAC_W);
        for (int k = 1; k <= FILTER_ORDER; k++)
            acc -= longint'(feedback[k]) * longint'(delay_line[k]);
        w_new = (acc + (longint'(1) << (iirdf2_pkg::FRAC_W - 1))) >>> iirdf2_pkg::FRAC_W;
        if (w_new > iirdf2_pkg::STATE_MAX) begin
            w_new = iirdf2_pkg::STATE_MAX;
            r.clipped = 1'b1;
        end else if (w_new < iirdf2_pkg::STATE_MIN) begin
            w_new = iirdf2_pkg::STATE_MIN;
            r.clipped = 1'b1;
        end
        acc = longint'(feedforward[0]) * w_new;
        for (int k = 1; k <= FILTER_ORDER; k++)
            acc += longint'(feedforward[k]) * longint'(delay_line[k]);
        y = (acc + (longint'(1) << (iirdf2_pkg::FRAC_W - 1))) >>> iirdf2_pkg::FRAC_W;
        if (y > iirdf2_pkg::OUT_MAX) begin
            y = iirdf2_pkg::OUT_MAX;
            r.clipped = 1'b1;
        end else if (y < iirdf2_pkg::OUT_MIN) begin
            y = iirdf2_pkg::OUT_MIN;
            r.clipped = 1'b1;
        end
        // shift the delay line; the new state becomes the one-sample delay
        for (int k = FILTER_ORDER; k >= 2; k--)
            delay_line[k] = delay_line[k-1];
        delay_line[1] = iirdf2_pkg::STATE_W'(w_new);
        r.sample_out = iirdf2_pkg::SAMPLE_W'(y);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Coefficient write. Caller guarantees the filter is idle. The enable is
    // dropped after the write edge, so back-to-back writes never double-assign it.
    task automatic write_coef(input logic [iirdf2_pkg::REG_IDX_W-1:0] idx,
                              input iirdf2_pkg::coef_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        case (idx)
            iirdf2_pkg::REG_B0: feedforward[0] = value;
            iirdf2_pkg::REG_B1: feedforward[1] = value;
            iirdf2_pkg::REG_B2: feedforward[2] = value;
            iirdf2_pkg::REG_B3: feedforward[3] = value;
            iirdf2_pkg::REG_A1: feedback[1]    = value;
            iirdf2_pkg::REG_A2: feedback[2]    = value;
            iirdf2_pkg::REG_A3: feedback[3]    = value;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // One input transaction. Valid stays up across back-to-back samples; it is
    // only lowered when a gap follows or the stream drains.
    task automatic send_sample(input logic signed [iirdf2_pkg::SAMPLE_W-1:0] x);
        filter_result_t predicted;
        s_valid     <= 1'b1;
        s_sample_in <= x;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_filter_output(x);
        expected_outputs.insert(expected_outputs.size(), predicted);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    // Stop sending, wait for every pending result, then let the pipeline settle.
    task automatic drain_filter();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [iirdf2_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return iirdf2_pkg::SAMPLE_W'(int'($urandom_range(0, 128)) - 64);
            default: return iirdf2_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    // Values within +/-span; a wild draw gives an extreme or full-range bits three times in four.
    function automatic iirdf2_pkg::coef_t random_coef(input int span, input bit wild);
        if (wild) begin
            case ($urandom_range(0, 3))
                0:       return COEF_MAX;
                1:       return COEF_MIN;
                2:       return iirdf2_pkg::coef_t'($urandom());
                default: ;
            endcase
        end
        return iirdf2_pkg::coef_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // ------------------------------------------------------------------
    // Result channel: ready with random stalls, plus one long hold on request.
    // ------------------------------------------------------------------
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (long_hold_cycles) @(posedge aclk);
                long_hold_cycles = 0;
                m_ready <= 1'b1;
            end else if (receiver_stalls && $urandom_range(0, 11) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Checker: every accepted result against the oldest prediction.
    always @(posedge aclk) begin
        filter_result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                $error("unexpected output transaction: sample_out %0d clipped %0b",
                       m_sample_out, m_clipped);
                error_count++;
            end else begin
                exp_r = expected_outputs.pop_front();
                if (m_sample_out !== exp_r.sample_out) begin
                    $error("sample_out: expected %0d, got %0d",
                           exp_r.sample_out, m_sample_out);
                    error_count++;
                end
                if (m_clipped !== exp_r.clipped) begin
                    $error("clipped: expected %0b, got %0b", exp_r.clipped, m_clipped);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset b0 = 1.0 and the rest are zero: a straight pass-through.
    task automatic test_reset_passthrough();
        send_sample(16'sd0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        drain_filter();
    endtask

    // A write to the hole in the register map must leave the bank untouched.
    task automatic test_unknown_index();
        write_coef(REG_UNUSED, COEF_MIN);
        write_coef(REG_UNUSED, COEF_MAX);
        send_sample(16'sd12345);
        drain_filter();
    endtask

    // b0 = 0.5 puts odd samples exactly on a half LSB; ties go toward +inf.
    task automatic test_rounding_ties();
        write_coef(iirdf2_pkg::REG_B0, COEF_HALF);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd3);
        send_sample(-16'sd3);
        drain_filter();
    endtask

    // Gain extremes on b0 push the output past 16 bits both ways.
    task automatic test_output_saturation();
        write_coef(iirdf2_pkg::REG_B0, COEF_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        drain_filter();
        write_coef(iirdf2_pkg::REG_B0, COEF_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        drain_filter();
    endtask

    // a1 = -8.0 grows the state eightfold per sample, plus the input, until the 24-bit clamp.
    task automatic test_state_saturation();
        write_coef(iirdf2_pkg::REG_B0, iirdf2_pkg::COEF_ONE);
        write_coef(iirdf2_pkg::REG_A1, COEF_MIN);
        repeat (5) send_sample(SAMPLE_MAX);
        drain_filter();
    endtask

    // Every tap live at once, with the delay line still holding clamped states.
    task automatic test_all_taps();
        write_coef(iirdf2_pkg::REG_B1, COEF_MIN);
        write_coef(iirdf2_pkg::REG_B2, COEF_MAX);
        write_coef(iirdf2_pkg::REG_B3, COEF_HALF);
        write_coef(iirdf2_pkg::REG_A1, iirdf2_pkg::coef_t'(18'sd4096));
        write_coef(iirdf2_pkg::REG_A2, COEF_MAX);
        write_coef(iirdf2_pkg::REG_A3, COEF_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd0);
        send_sample(16'sd777);
        send_sample(SAMPLE_MAX);
        drain_filter();
    endtask

    // Several random coefficient sets, feedforward draws always wild. Most keep the
    // feedback small to stay in the linear range; every third set goes wild there too.
    task automatic test_random_settings();
        bit wild;
        for (int s = 0; s < 8; s++) begin
            wild = (s % 3 == 0);
            for (int r = 0; r < 7; r++) begin
                if (r < 4)
                    write_coef(COEF_REGS[r], random_coef(20000, 1'b1));
                else
                    write_coef(COEF_REGS[r], random_coef(3000, wild));
            end
            if ($urandom_range(0, 1) == 0)
                write_coef(REG_UNUSED, iirdf2_pkg::coef_t'($urandom()));
            repeat (90) send_sample(random_sample());
            drain_filter();
        end
    endtask

    // Receiver holds off for a long stretch while samples keep coming, so the
    // output register fills and the input stalls.
    task automatic test_backpressure();
        sender_gaps = 1'b0;
        long_hold_cycles = 300;
        repeat (60) send_sample(random_sample());
        drain_filter();
        sender_gaps = 1'b1;
    endtask

    // Final stretch: full-rate traffic with no idling on either side.
    task automatic test_steady_stream();
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        write_coef(iirdf2_pkg::REG_B0, iirdf2_pkg::coef_t'(18'sd8000));
        write_coef(iirdf2_pkg::REG_B1, iirdf2_pkg::coef_t'(18'sd6000));
        write_coef(iirdf2_pkg::REG_B2, iirdf2_pkg::coef_t'(-18'sd3000));
        write_coef(iirdf2_pkg::REG_B3, iirdf2_pkg::coef_t'(18'sd1500));
        write_coef(iirdf2_pkg::REG_A1, iirdf2_pkg::coef_t'(-18'sd9000));
        write_coef(iirdf2_pkg::REG_A2, iirdf2_pkg::coef_t'(18'sd2500));
        write_coef(iirdf2_pkg::REG_A3, iirdf2_pkg::coef_t'(-18'sd500));
        repeat (200) send_sample(random_sample());
        drain_filter();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        error_count      = 0;
        sender_gaps      = 1'b1;
        receiver_stalls  = 1'b1;
        long_hold_cycles = 0;
        feedforward[0]   = iirdf2_pkg::COEF_ONE;
        for (int k = 1; k <= iirdf2_pkg::MAX_ORDER; k++) begin
            feedforward[k] = '0;
            feedback[k]    = '0;
            delay_line[k]  = '0;
        end
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_sample_in <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_passthrough();
        test_unknown_index();
        test_rounding_ties();
        test_output_saturation();
        test_state_saturation();
        test_all_taps();
        test_random_settings();
        test_backpressure();
        test_steady_stream();

        if (error_count == 0 && expected_outputs.size() == 0)
            $display("iir_direct_form_two_filter verification clean");
        else
            $display("iir_direct_form_two_filter verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("iir_direct_form_two_filter verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/iirdf2_pkg.sv
rtl/iirdf2_seq.sv
rtl/iirdf2_dp.sv
rtl/iir_direct_form_two_filter.sv
test/testbench.sv
